/* sv/kpc_pkg.sv */
// Shared types and constants for the keypad press classifier.
// Depends on nothing; every other file of the block imports it.
package kpc_pkg;

   // Configuration port geometry: four 32-bit registers at 4-byte spacing.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_KEY_LOCK,
      CSR_PIN_ACTION,
      CSR_EXEMPT_MASK,
      CSR_SHORT_POST
   } csr_index_type;

   // Press latch codes.
   localparam logic [1:0] LATCH_IDLE  = 2'd0;
   localparam logic [1:0] LATCH_SHORT = 2'd1;
   localparam logic [1:0] LATCH_LONG  = 2'd2;

   // Hold accumulator thresholds.
   localparam logic [7:0] LATCH_MIN     = 8'd3;
   localparam logic [7:0] LONG_MIN      = 8'd75;
   localparam logic [7:0] RELEASE_CLAMP = 8'd4;
   localparam logic [7:0] ACC_MAX       = 8'hff;

   typedef struct packed {
      logic       req_type;
      logic       matrix_valid;
      logic [3:0] matrix_key;
      logic       ptt_down;
      logic       side1_down;
      logic       side2_down;
      logic       entering_pin;
      logic [7:0] tick_count;
   } kpc_req_type;

   typedef struct packed {
      logic [4:0] pressed_key;
      logic [1:0] keys_in_use;
      logic [4:0] long_key;
      logic [4:0] short_key;
      logic       ptt_active;
      logic       backlight_wake;
   } kpc_rsp_type;

   typedef struct packed {
      logic        key_lock;
      logic        pin_action;
      logic [15:0] lock_exempt_mask;
      logic        short_post_enable;
   } kpc_cfg_type;

   // One entry of the per-key store.
   typedef struct packed {
      logic [7:0] acc;
      logic [1:0] latch;
   } kpc_entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic take;      // input transaction accepted this cycle
      logic rd_en;     // read key store at rd_idx
      logic proc_en;   // update key proc_idx from the read data
      logic load_out;  // move finished result into the output register
   } kpc_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;  // output register can take a result this cycle
   } kpc_status_type;

endpackage

/* sv/keypad_press_classifier.sv */
// Keypad press classifier top level: debounce and short/long classification of keys.
// A tick transaction reads the key store once per key, applies the update of each key,
// waits in a finish state until the output register is free and is then moved into it;
// a read transaction skips the walk. A new transaction is taken only once the previous
// one has been handed to the output register; a tick walks the single read port of the
// key store one key a cycle.
// Reset is synchronous: key latches read as idle at once via per-key valid bits.
// Depends on kpc_pkg, kpc_csr, kpc_ctrl and kpc_dp.
module keypad_press_classifier
   import kpc_pkg::*;
#(
   parameter int MATRIX_KEYS = 16,
   parameter int TOTAL_KEYS  = 19
)
(
   input  logic                  clock,
   input  logic                  reset,
   // input transactions
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kpc_req_type           req_data,
   // result transactions
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kpc_rsp_type           rsp_data,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SCAN_W = $clog2(MATRIX_KEYS + 3);
   localparam int ADDR_W = $clog2(TOTAL_KEYS);
   localparam int IDX_W  = (SCAN_W > ADDR_W) ? SCAN_W : ADDR_W;

   kpc_cfg_type      cfg;
   kpc_cmd_type      cmd;
   kpc_status_type   status;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] proc_idx;

   // Register file; to be written only while no transaction is in flight (not enforced here).
   kpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer: take a transaction, walk every key index in order for a tick (a read
   // skips the walk), then hand the result to the output register, holding while it is still occupied.
   kpc_ctrl #(
      .MATRIX_KEYS (MATRIX_KEYS),
      .TOTAL_KEYS  (TOTAL_KEYS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_read (req_data.req_type),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd),
      .rd_idx      (rd_idx),
      .proc_idx    (proc_idx)
   );

   // Key store and per-key update. Keys are updated in index order so that the
   // long key and short-press key follow the same precedence as a serial scan.
   kpc_dp #(
      .MATRIX_KEYS (MATRIX_KEYS),
      .TOTAL_KEYS  (TOTAL_KEYS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .proc_idx  (proc_idx),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/kpc_csr.sv */
// Configuration registers of the keypad press classifier, APB-style port.
// Depends on kpc_pkg.
module kpc_csr
   import kpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output kpc_cfg_type           cfg
);

   kpc_cfg_type   cfg_ff;
   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_lock          <= 1'b0;
         cfg_ff.pin_action        <= 1'b0;
         cfg_ff.lock_exempt_mask  <= '0;
         cfg_ff.short_post_enable <= 1'b1;
      end else if (wr_en) begin
         unique case (index)
            CSR_KEY_LOCK:    cfg_ff.key_lock          <= pwdata[0];
            CSR_PIN_ACTION:  cfg_ff.pin_action        <= pwdata[0];
            CSR_EXEMPT_MASK: cfg_ff.lock_exempt_mask  <= pwdata[15:0];
            CSR_SHORT_POST:  cfg_ff.short_post_enable <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         CSR_KEY_LOCK:    prdata[0]    = cfg_ff.key_lock;
         CSR_PIN_ACTION:  prdata[0]    = cfg_ff.pin_action;
         CSR_EXEMPT_MASK: prdata[15:0] = cfg_ff.lock_exempt_mask;
         CSR_SHORT_POST:  prdata[0]    = cfg_ff.short_post_enable;
      endcase
   end

endmodule

/* sv/kpc_ctrl.sv */
// Sequencer of the keypad press classifier: walks the key store once per tick.
// Depends on kpc_pkg; drives kpc_dp through the command struct.
module kpc_ctrl
   import kpc_pkg::*;
#(
   parameter int MATRIX_KEYS = 16,
   parameter int TOTAL_KEYS  = 19,
   localparam int SCAN_W = $clog2(MATRIX_KEYS + 3),
   localparam int ADDR_W = $clog2(TOTAL_KEYS),
   localparam int IDX_W  = (SCAN_W > ADDR_W) ? SCAN_W : ADDR_W
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_is_read,
   output logic             req_stall,
   input  kpc_status_type   status,
   output kpc_cmd_type      cmd,
   output logic [IDX_W-1:0] rd_idx,
   output logic [IDX_W-1:0] proc_idx
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_KEYS + 2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic             proc_en_ff;
   logic [IDX_W-1:0] proc_idx_ff;
   logic             take;

   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         proc_en_ff  <= 1'b0;
         proc_idx_ff <= '0;
      end else begin
         proc_en_ff  <= (state_ff == ST_SCAN);
         proc_idx_ff <= cnt_ff;
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (take) begin
                  state_ff <= req_is_read ? ST_FINISH : ST_SCAN;
               end
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign cmd.take     = take;
   assign cmd.rd_en    = (state_ff == ST_SCAN);
   assign cmd.proc_en  = proc_en_ff;
   assign cmd.load_out = (state_ff == ST_FINISH) && status.out_free;
   assign rd_idx       = cnt_ff;
   assign proc_idx     = proc_idx_ff;

   // A tick transaction starts the walk at key zero.
   a_scan_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.take && !req_is_read |=> cmd.rd_en && (rd_idx == '0))
      else $error("key walk did not start at key zero");

   // Each read is followed by the update of the same key.
   a_proc_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> cmd.proc_en && (proc_idx == $past(rd_idx)))
      else $error("key update does not follow its read");

   // No key update runs while a new transaction is taken.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !cmd.proc_en && !cmd.load_out)
      else $error("transaction taken during a walk");

endmodule

/* sv/kpc_dp.sv */
// Datapath of the keypad press classifier: key store, per-key update, output register.
// Depends on kpc_pkg; commanded by kpc_ctrl.
module kpc_dp
   import kpc_pkg::*;
#(
   parameter int MATRIX_KEYS = 16,
   parameter int TOTAL_KEYS  = 19,
   localparam int SCAN_W = $clog2(MATRIX_KEYS + 3),
   localparam int ADDR_W = $clog2(TOTAL_KEYS),
   localparam int IDX_W  = (SCAN_W > ADDR_W) ? SCAN_W : ADDR_W,
   localparam int KEY_W  = $clog2(TOTAL_KEYS + 1)
)
(
   input  logic             clock,
   input  logic             reset,
   input  kpc_cfg_type      cfg,
   input  kpc_req_type      req_data,
   input  kpc_cmd_type      cmd,
   input  logic [IDX_W-1:0] rd_idx,
   input  logic [IDX_W-1:0] proc_idx,
   output kpc_status_type   status,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kpc_rsp_type      rsp_data
);

   localparam logic [KEY_W-1:0] NO_KEY = KEY_W'(TOTAL_KEYS);

   kpc_entry_type   key_mem [TOTAL_KEYS];
   logic [TOTAL_KEYS-1:0] valid_ff;
   kpc_entry_type   rdata_ff;
   logic            rvalid_ff;

   kpc_req_type     item_ff;
   logic [KEY_W-1:0] long_key_ff;
   logic [KEY_W-1:0] short_key_ff;
   logic [KEY_W-1:0] short_out_ff;
   logic [KEY_W-1:0] pressed_ff;
   logic [1:0]      in_use_ff;
   logic            wake_ff;
   logic            ptt_nz_ff;
   logic            side1_nz_ff;
   logic            rsp_valid_ff;
   kpc_rsp_type     rsp_data_ff;

   // per-key update
   logic             is_matrix, is_ptt, is_side1, is_side2;
   logic             exists, processed, key_active, held, have;
   logic             exempt, reached, wake_hit;
   logic [7:0]       acc_cur, acc_nxt, clamp;
   logic [1:0]       lat_cur, lat_nxt;
   logic [8:0]       sum;
   logic [KEY_W-1:0] key_id, long_key_in, short_key_in;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic             rd_in_range;

   assign rd_addr     = rd_idx[ADDR_W-1:0];
   assign wr_addr     = proc_idx[ADDR_W-1:0];
   assign rd_in_range = 32'(rd_idx) < TOTAL_KEYS;
   assign key_id      = KEY_W'(proc_idx);

   always_comb begin
      is_matrix = 32'(proc_idx) < MATRIX_KEYS;
      is_ptt    = 32'(proc_idx) == MATRIX_KEYS;
      is_side1  = 32'(proc_idx) == MATRIX_KEYS + 1;
      is_side2  = 32'(proc_idx) == MATRIX_KEYS + 2;
      exists    = 32'(proc_idx) < TOTAL_KEYS;

      exempt = cfg.lock_exempt_mask[item_ff.matrix_key];
      have   = item_ff.matrix_valid && (32'(item_ff.matrix_key) < MATRIX_KEYS) &&
               (!cfg.key_lock || item_ff.entering_pin || exempt);

      priority if (is_matrix) begin
         processed = 1'b1;
         held      = have && (32'(proc_idx) == 32'(item_ff.matrix_key));
      end else if (is_ptt) begin
         processed = !(cfg.key_lock && cfg.pin_action);
         held      = item_ff.ptt_down;
      end else if (is_side1) begin
         processed = !(cfg.key_lock && cfg.pin_action);
         held      = item_ff.side1_down;
      end else begin
         processed = !cfg.key_lock;
         held      = item_ff.side2_down;
      end
      key_active = cmd.proc_en && exists && processed;

      acc_cur = rvalid_ff ? rdata_ff.acc : '0;
      lat_cur = rvalid_ff ? rdata_ff.latch : LATCH_IDLE;
      sum     = {1'b0, acc_cur} + {1'b0, item_ff.tick_count};
      clamp   = (acc_cur > LATCH_MIN) ? RELEASE_CLAMP : acc_cur;

      acc_nxt      = acc_cur;
      lat_nxt      = lat_cur;
      long_key_in  = long_key_ff;
      short_key_in = short_key_ff;
      wake_hit     = 1'b0;
      reached      = 1'b0;

      if (held) begin
         if (lat_cur == LATCH_LONG) begin
            // record the first key seen held long
            if (long_key_ff == NO_KEY) begin
               long_key_in = key_id;
               wake_hit    = 1'b1;
            end
         end else begin
            acc_nxt = sum[8] ? ACC_MAX : sum[7:0];
            if (acc_nxt > LATCH_MIN) begin
               lat_nxt = (acc_nxt > LONG_MIN) ? LATCH_LONG : LATCH_SHORT;
               if (is_ptt || is_side1) begin
                  wake_hit = 1'b1;
               end
            end
         end
      end else begin
         // release: count the clamped accumulator down
         if (clamp <= item_ff.tick_count) begin
            acc_nxt = '0;
            reached = 1'b1;
         end else begin
            acc_nxt = clamp - item_ff.tick_count;
         end
         if (reached && (lat_cur != LATCH_IDLE)) begin
            if (lat_cur == LATCH_SHORT) begin
               if (cfg.short_post_enable) begin
                  short_key_in = key_id;
               end
               wake_hit = 1'b1;
            end
            lat_nxt     = LATCH_IDLE;
            long_key_in = NO_KEY;
         end
      end
   end

   // Key store: one read and one write port, read data registered.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= key_mem[rd_addr];
      end
      if (key_active) begin
         key_mem[wr_addr] <= '{acc: acc_nxt, latch: lat_nxt};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rvalid_ff    <= 1'b0;
         long_key_ff  <= NO_KEY;
         short_key_ff <= NO_KEY;
         ptt_nz_ff    <= 1'b0;
         side1_nz_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rvalid_ff <= rd_in_range && valid_ff[rd_addr];
         end
         if (cmd.take && req_data.req_type) begin
            short_key_ff <= NO_KEY;
         end else if (key_active) begin
            valid_ff[wr_addr] <= 1'b1;
            long_key_ff       <= long_key_in;
            short_key_ff      <= short_key_in;
            if (is_ptt) begin
               ptt_nz_ff <= (lat_nxt != LATCH_IDLE);
            end
            if (is_side1) begin
               side1_nz_ff <= (lat_nxt != LATCH_IDLE);
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the transaction in flight, and the output register.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_ff      <= req_data;
         pressed_ff   <= NO_KEY;
         in_use_ff    <= '0;
         wake_ff      <= 1'b0;
         short_out_ff <= req_data.req_type ? short_key_ff : NO_KEY;
      end else if (key_active) begin
         in_use_ff <= in_use_ff ^ lat_nxt;
         wake_ff   <= wake_ff | wake_hit;
         if ((is_matrix || is_side2) && (lat_nxt != LATCH_IDLE)) begin
            pressed_ff <= key_id;
         end
      end
      if (cmd.load_out) begin
         rsp_data_ff.pressed_key    <= 5'(pressed_ff);
         rsp_data_ff.keys_in_use    <= in_use_ff;
         rsp_data_ff.long_key       <= 5'(long_key_ff);
         rsp_data_ff.short_key      <= 5'(short_out_ff);
         rsp_data_ff.ptt_active     <= ptt_nz_ff || side1_nz_ff;
         rsp_data_ff.backlight_wake <= wake_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   // A read transaction leaves the recorded long key alone.
   a_read_keeps_long: assert property (@(posedge clock) disable iff (reset)
      cmd.take && req_data.req_type |=> long_key_ff == $past(long_key_ff))
      else $error("read transaction changed the long key");

   // A loaded result is presented in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

   // Hold a stalled result unchanged.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result changed");

endmodule
